>>> design/lkvc_pkg.sv
// ----------------------------------------------------------------------------
// lkvc_pkg
// Shared constants and types for the LRU key-value cache.
// ----------------------------------------------------------------------------
package lkvc_pkg;

   localparam int KEY_W           = 32;
   localparam int VAL_W           = 32;
   localparam int CAP_W           = 5;
   localparam int MAX_ENTRIES_DEF = 16;

   localparam logic [CAP_W-1:0] CAP_RESET  = CAP_W'(16);
   localparam logic [VAL_W-1:0] MISS_VALUE = '1;

   // request kinds carried on req_tuser
   localparam logic OP_GET = 1'b0;
   localparam logic OP_PUT = 1'b1;

   typedef enum logic [3:0] {
      S_IDLE   = 4'b0001,
      S_SEARCH = 4'b0010,
      S_DECIDE = 4'b0100,
      S_TOUCH  = 4'b1000
   } state_type;

endpackage

>>> design/lkvc_ram.sv
// ----------------------------------------------------------------------------
// lkvc_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module lkvc_ram
   import lkvc_pkg::*;
#(
   parameter int WIDTH = KEY_W,
   parameter int DEPTH = MAX_ENTRIES_DEF,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

>>> design/lru_key_value_cache.sv
// ----------------------------------------------------------------------------
// lru_key_value_cache
// Fully associative key-value store with least-recently-used replacement.
// ----------------------------------------------------------------------------
//
//  Channel | Ports                          | Word contents (low bit up)
//  --------+--------------------------------+----------------------------------
//  request | req_tvalid/tready/tdata/tuser  | tdata: key[31:0], value[63:32];
//          |                                | tuser: op (0 get, 1 put)
//  result  | rsp_tvalid/tready/tdata/tuser  | tdata: read_value; tuser: hit
//  config  | csr_we, csr_wdata              | capacity[4:0]
//
//  Flow: one request at a time. A hit or an update takes two sweeps
//  through the live entries of the entry memories, one read a cycle: a key
//  search, then a rank update that makes the touched entry most recent. A
//  get miss and a put of a new key into a non-full store skip the update.
//  Reset: synchronous; clears the fill count, so the store starts empty
//  without a clearing pass. Capacity returns to 16.
//  Stalls: a finished get result waits in the output register; the block
//  takes the next request meanwhile and holds only when a new get result
//  is ready while the old one has not been taken.
// ----------------------------------------------------------------------------
module lru_key_value_cache
   import lkvc_pkg::*;
#(
   parameter int MAX_ENTRIES = MAX_ENTRIES_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   // request
   input  logic                    req_tvalid,
   output logic                    req_tready,
   input  logic [KEY_W+VAL_W-1:0]  req_tdata,   // key[31:0], value[63:32]
   input  logic                    req_tuser,   // op
   // result
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   output logic signed [VAL_W-1:0] rsp_tdata,   // read_value[31:0]
   output logic                    rsp_tuser,   // hit
   // configuration
   input  logic                    csr_we,
   input  logic [CAP_W-1:0]        csr_wdata    // capacity[4:0]
);

   localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
   localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;
   localparam int KV_W  = KEY_W + VAL_W;

   // control state
   state_type          state_ff, state_in;
   logic [CNT_W-1:0]   fill_ff, fill_in;
   logic [CAP_W-1:0]   cap_ff, cap_in;
   logic               chk_valid_ff, chk_valid_in;
   logic               rsp_valid_ff, rsp_valid_in;

   // payload state
   logic               op_ff, op_in;
   logic [KEY_W-1:0]   key_ff, key_in;
   logic [VAL_W-1:0]   value_ff, value_in;
   logic [CNT_W-1:0]   scan_ff, scan_in;
   logic [IDX_W-1:0]   chk_idx_ff, chk_idx_in;
   logic               found_ff, found_in;
   logic [IDX_W-1:0]   slot_ff, slot_in;
   logic [IDX_W-1:0]   rank_hit_ff, rank_hit_in;
   logic [IDX_W-1:0]   victim_ff, victim_in;
   logic [VAL_W-1:0]   hit_value_ff, hit_value_in;
   logic               rsp_hit_ff, rsp_hit_in;
   logic [VAL_W-1:0]   rsp_data_ff, rsp_data_in;

   // memory ports
   logic               kv_we;
   logic [IDX_W-1:0]   kv_waddr;
   logic [KV_W-1:0]    kv_wdata;
   logic [KV_W-1:0]    kv_rdata;
   logic               rank_we;
   logic [IDX_W-1:0]   rank_waddr;
   logic [IDX_W-1:0]   rank_wdata;
   logic [IDX_W-1:0]   rank_rdata;
   logic [IDX_W-1:0]   scan_idx;

   // effective capacity: zero counts as one, clamp at the memory depth
   logic [CMP_W-1:0]   cap_nz;
   logic [CMP_W-1:0]   cap_eff;
   logic               store_full;
   logic [CNT_W-1:0]   fill_m1;
   logic               rsp_free;

   assign scan_idx   = scan_ff[IDX_W-1:0];
   assign fill_m1    = fill_ff - CNT_W'(1);
   assign cap_nz     = (cap_ff == '0) ? CMP_W'(1) : CMP_W'(cap_ff);
   assign cap_eff    = (cap_nz > CMP_W'(MAX_ENTRIES)) ? CMP_W'(MAX_ENTRIES) : cap_nz;
   assign store_full = CMP_W'(fill_ff) >= cap_eff;
   assign rsp_free   = !rsp_valid_ff || rsp_tready;

   // key and value of each entry share one word: key low, value high
   lkvc_ram #(
      .WIDTH (KV_W),
      .DEPTH (MAX_ENTRIES),
      .AW    (IDX_W)
   ) u_kv_ram (
      .clock (clock),
      .we    (kv_we),
      .waddr (kv_waddr),
      .wdata (kv_wdata),
      .raddr (scan_idx),
      .rdata (kv_rdata)
   );

   // recency rank: 0 is least recent, fill-1 most recent
   lkvc_ram #(
      .WIDTH (IDX_W),
      .DEPTH (MAX_ENTRIES),
      .AW    (IDX_W)
   ) u_rank_ram (
      .clock (clock),
      .we    (rank_we),
      .waddr (rank_waddr),
      .wdata (rank_wdata),
      .raddr (scan_idx),
      .rdata (rank_rdata)
   );

   always_comb begin
      state_in     = state_ff;
      fill_in      = fill_ff;
      cap_in       = csr_we ? csr_wdata : cap_ff;
      chk_valid_in = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      op_in        = op_ff;
      key_in       = key_ff;
      value_in     = value_ff;
      scan_in      = scan_ff;
      chk_idx_in   = chk_idx_ff;
      found_in     = found_ff;
      slot_in      = slot_ff;
      rank_hit_in  = rank_hit_ff;
      victim_in    = victim_ff;
      hit_value_in = hit_value_ff;
      rsp_hit_in   = rsp_hit_ff;
      rsp_data_in  = rsp_data_ff;

      kv_we        = 1'b0;
      kv_waddr     = slot_ff;
      kv_wdata     = {value_ff, key_ff};
      rank_we      = 1'b0;
      rank_waddr   = chk_idx_ff;
      rank_wdata   = rank_rdata;

      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               op_in    = req_tuser;
               key_in   = req_tdata[KEY_W-1:0];
               value_in = req_tdata[KV_W-1:KEY_W];
               scan_in  = '0;
               found_in = 1'b0;
               state_in = S_SEARCH;
            end
         end

         S_SEARCH: begin
            // issue one read a cycle, compare the word that returns
            if (scan_ff < fill_ff) begin
               chk_valid_in = 1'b1;
               chk_idx_in   = scan_idx;
               scan_in      = scan_ff + CNT_W'(1);
            end
            if (chk_valid_ff) begin
               if (kv_rdata[KEY_W-1:0] == key_ff) begin
                  found_in     = 1'b1;
                  slot_in      = chk_idx_ff;
                  rank_hit_in  = rank_rdata;
                  hit_value_in = kv_rdata[KV_W-1:KEY_W];
               end
               if (rank_rdata == '0) begin
                  victim_in = chk_idx_ff;
               end
            end
            if (!(scan_ff < fill_ff) && !chk_valid_ff) begin
               state_in = S_DECIDE;
            end
         end

         S_DECIDE: begin
            scan_in = '0;
            if (op_ff == OP_GET) begin
               // hold until the output register can take the result
               if (rsp_free) begin
                  rsp_valid_in = 1'b1;
                  rsp_hit_in   = found_ff;
                  rsp_data_in  = found_ff ? hit_value_ff : MISS_VALUE;
                  state_in     = found_ff ? S_TOUCH : S_IDLE;
               end
            end else if (found_ff) begin
               kv_we    = 1'b1;
               state_in = S_TOUCH;
            end else if (store_full) begin
               // replace the least recent entry, then promote it
               kv_we       = 1'b1;
               kv_waddr    = victim_ff;
               slot_in     = victim_ff;
               rank_hit_in = '0;
               state_in    = S_TOUCH;
            end else begin
               // append as most recent
               kv_we      = 1'b1;
               kv_waddr   = fill_ff[IDX_W-1:0];
               rank_we    = 1'b1;
               rank_waddr = fill_ff[IDX_W-1:0];
               rank_wdata = fill_ff[IDX_W-1:0];
               fill_in    = fill_ff + CNT_W'(1);
               state_in   = S_IDLE;
            end
         end

         S_TOUCH: begin
            // read rank j while writing back rank j-1
            if (scan_ff < fill_ff) begin
               chk_valid_in = 1'b1;
               chk_idx_in   = scan_idx;
               scan_in      = scan_ff + CNT_W'(1);
            end
            if (chk_valid_ff) begin
               if (chk_idx_ff == slot_ff) begin
                  rank_we    = 1'b1;
                  rank_wdata = fill_m1[IDX_W-1:0];
               end else if (rank_rdata > rank_hit_ff) begin
                  rank_we    = 1'b1;
                  rank_wdata = rank_rdata - IDX_W'(1);
               end
            end
            if (!(scan_ff < fill_ff) && !chk_valid_ff) begin
               state_in = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         fill_ff      <= '0;
         cap_ff       <= CAP_RESET;
         chk_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         cap_ff       <= cap_in;
         chk_valid_ff <= chk_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff        <= op_in;
      key_ff       <= key_in;
      value_ff     <= value_in;
      scan_ff      <= scan_in;
      chk_idx_ff   <= chk_idx_in;
      found_ff     <= found_in;
      slot_ff      <= slot_in;
      rank_hit_ff  <= rank_hit_in;
      victim_ff    <= victim_in;
      hit_value_ff <= hit_value_in;
      rsp_hit_ff   <= rsp_hit_in;
      rsp_data_ff  <= rsp_data_in;
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_hit_ff;

endmodule

>>> design/lkvc_checker.sv
// ----------------------------------------------------------------------------
// lkvc_checker
// Port-level assertions for the LRU key-value cache, bound to the top level.
// ----------------------------------------------------------------------------
module lkvc_checker
   import lkvc_pkg::*;
(
   input logic                    clock,
   input logic                    reset,
   input logic                    req_tvalid,
   input logic                    req_tready,
   input logic                    rsp_tvalid,
   input logic                    rsp_tready,
   input logic signed [VAL_W-1:0] rsp_tdata,
   input logic                    rsp_tuser
);

   // a stalled result word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result word changed while stalled");

   // a miss always reads back all ones
   a_miss_value: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tdata == MISS_VALUE)
      else $error("miss result is not all ones");

   // one request at a time: accepting drops ready for the search
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("ready stayed high after an accepted request");

   // reset leaves no result pending
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

endmodule

bind lru_key_value_cache lkvc_checker u_lkvc_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
